### hw/rtl/lotp_pkg.sv
// Shared types and constants for the lottery thread picker.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package lotp_pkg;

    // Fixed field widths of the channels and the configuration port.
    localparam int RAND_W      = 32;
    localparam int TOTAL_W     = 18;
    localparam int THREAD_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int TCOUNT_W    = 3;
    localparam int DIV_CNT_W   = $clog2(RAND_W);

    // Parameter defaults.
    localparam int NUM_THREADS_DEF = 4;
    localparam int TICKET_BITS_DEF = 16;

    // Reset value of the thread count register.
    localparam logic [TCOUNT_W-1:0] TCOUNT_RESET = TCOUNT_W'(4);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICKETS_0    = 3'd0,
        REG_TICKETS_1    = 3'd1,
        REG_TICKETS_2    = 3'd2,
        REG_TICKETS_3    = 3'd3,
        REG_THREAD_COUNT = 3'd4
    } lotp_reg_t;

    // Request codes.
    typedef enum logic {
        REQ_DRAW   = 1'b0,
        REQ_FINISH = 1'b1
    } lotp_req_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_PICK,
        ST_DONE
    } lotp_state_t;

endpackage

### hw/rtl/lotp_req_if.sv
// Request and result channel interfaces of the lottery thread picker.
// Depends on lotp_pkg for the field widths.
`timescale 1ns / 1ps

interface lotp_req_if;
    import lotp_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [RAND_W-1:0] random_value;

    modport source (output valid, output req_type, output random_value, input ready);
    modport sink   (input valid, input req_type, input random_value, output ready);
endinterface

interface lotp_res_if;
    import lotp_pkg::*;

    logic                valid;
    logic                ready;
    logic [THREAD_W-1:0] chosen_thread;
    logic                chosen_valid;
    logic                all_done;
    logic [TOTAL_W-1:0]  ticket_total;

    modport source (output valid, output chosen_thread, output chosen_valid,
                    output all_done, output ticket_total, input ready);
    modport sink   (input valid, input chosen_thread, input chosen_valid,
                    input all_done, input ticket_total, output ready);
endinterface

### hw/rtl/lotp_rem.sv
// Bit-serial restoring remainder unit: random word modulo the ticket total.
// Depends on lotp_pkg; one quotient bit per cycle.
`timescale 1ns / 1ps

module lotp_rem (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [lotp_pkg::RAND_W-1:0]    dividend,
    input  logic [lotp_pkg::TOTAL_W-1:0]   divisor,
    output logic                           done,
    output logic [lotp_pkg::TOTAL_W-1:0]   remainder
);
    import lotp_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [RAND_W-1:0]    dvd_reg;
    logic [TOTAL_W-1:0]   dsr_reg;
    logic [TOTAL_W-1:0]   rem_reg;

    logic [TOTAL_W:0]     shifted;
    logic                 fits;
    logic [TOTAL_W-1:0]   rem_next;

    // The partial remainder stays below the divisor, so the shifted value
    // is below twice the divisor and one subtract restores it.
    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[RAND_W-1]};
        fits     = shifted >= {1'b0, dsr_reg};
        rem_next = fits ? TOTAL_W'(shifted - {1'b0, dsr_reg}) : shifted[TOTAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            dsr_reg  <= '0;
            rem_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= dividend;
            dsr_reg  <= divisor;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_reg << 1;
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(RAND_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### hw/rtl/lottery_thread_picker.sv
// Lottery thread picker: top level with sequencer, ticket registers and state.
// Depends on lotp_pkg, lotp_req_if / lotp_res_if and lotp_rem.
//
// Usage: each request word on req carries req_type (draw, or finish the
// current thread then draw) and a 32-bit random value. The block answers
// with exactly one result word on res: the chosen thread and its valid
// flag, the all-done flag and the candidates' ticket total.
// Ticket counts and the thread count are written through cfg_we, cfg_index
// and cfg_data, by the user only while no request is in flight; the block
// itself does not enforce this.
// Timing: a request is taken when req.valid and req.ready are high; ready
// is low while a request is worked on. The candidate ticket total is summed
// one thread per cycle, the serial remainder unit then works out the ticket,
// the pick walks the threads again, and the result register is loaded last.
// Unless the result side stalls, the remainder unit sets the rate.
// Reset: all tickets are 1, four threads in use, none finished, no current
// thread. If res.ready is low, the result word holds; the block still takes
// and works the next request, then waits in its final step until the held
// word leaves.
`timescale 1ns / 1ps

module lottery_thread_picker #(
    parameter int NUM_THREADS = lotp_pkg::NUM_THREADS_DEF,
    parameter int TICKET_BITS = lotp_pkg::TICKET_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    lotp_req_if.sink                       req,
    lotp_res_if.source                     res,
    input  logic                           cfg_we,
    input  logic [lotp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lotp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lotp_pkg::*;

    localparam int IDX_W = $clog2(NUM_THREADS);
    localparam int TKT_W = (TICKET_BITS < CFG_DATA_W) ? TICKET_BITS : CFG_DATA_W;

    // Configuration.
    logic [TKT_W-1:0]       tickets_reg [NUM_THREADS];
    logic [TCOUNT_W-1:0]    tcount_reg;

    // Scheduler state.
    logic [NUM_THREADS-1:0] finished_reg, finished_next;
    logic [IDX_W-1:0]       cur_thread_reg, cur_thread_next;
    logic                   cur_valid_reg, cur_valid_next;

    // Sequencer and working registers.
    lotp_state_t            state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [NUM_THREADS-1:0] cand_reg, cand_next;
    logic [RAND_W-1:0]      rand_reg, rand_next;
    logic [TOTAL_W-1:0]     total_reg, total_next;
    logic [TOTAL_W-1:0]     run_reg, run_next;
    logic [TOTAL_W-1:0]     ticket_reg, ticket_next;
    logic [IDX_W-1:0]       pick_reg, pick_next;
    logic                   pick_valid_reg, pick_valid_next;
    logic                   done_flag_reg, done_flag_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [THREAD_W-1:0]    out_thread_reg, out_thread_next;
    logic                   out_chosen_reg, out_chosen_next;
    logic                   out_done_reg, out_done_next;
    logic [TOTAL_W-1:0]     out_total_reg, out_total_next;

    // Remainder unit.
    logic                   div_start;
    logic                   div_done;
    logic [TOTAL_W-1:0]     div_rem;

    // Request decode.
    logic [TCOUNT_W-1:0]    n_use;
    logic                   cur_in_use;
    logic [NUM_THREADS-1:0] fin_mark;
    logic [NUM_THREADS-1:0] cand_main;
    logic [NUM_THREADS-1:0] cand_new;
    logic [TOTAL_W-1:0]     tkt_sel;
    logic                   last_idx;

    lotp_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rand_reg),
        .divisor   (total_next),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_THREADS; i++)
            begin
                tickets_reg[i] <= TKT_W'(1);
            end
            tcount_reg <= TCOUNT_RESET;
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < NUM_THREADS; i++)
            begin
                if (cfg_index == CFG_IDX_W'(REG_TICKETS_0) + CFG_IDX_W'(i))
                begin
                    tickets_reg[i] <= cfg_data[TKT_W-1:0];
                end
            end
            if (cfg_index == REG_THREAD_COUNT)
            begin
                tcount_reg <= cfg_data[TCOUNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        n_use = (tcount_reg > TCOUNT_W'(NUM_THREADS)) ? TCOUNT_W'(NUM_THREADS) : tcount_reg;
        cur_in_use = cur_valid_reg && (TCOUNT_W'(cur_thread_reg) < n_use);

        fin_mark  = finished_reg;
        cand_main = '0;
        cand_new  = '0;
        for (int i = 0; i < NUM_THREADS; i++)
        begin
            if ((req.req_type == REQ_FINISH) && cur_valid_reg
                && (cur_thread_reg == IDX_W'(i)))
            begin
                fin_mark[i] = 1'b1;
            end
        end
        for (int i = 0; i < NUM_THREADS; i++)
        begin
            cand_main[i] = (TCOUNT_W'(i) < n_use) && !fin_mark[i]
                           && !(cur_in_use && (cur_thread_reg == IDX_W'(i)));
        end
        cand_new = cand_main;
        // The current thread runs again only when no other thread is left.
        if ((cand_main == '0) && cur_in_use && !fin_mark[cur_thread_reg])
        begin
            for (int i = 0; i < NUM_THREADS; i++)
            begin
                cand_new[i] = (cur_thread_reg == IDX_W'(i));
            end
        end

        tkt_sel  = cand_reg[idx_reg] ? TOTAL_W'(tickets_reg[idx_reg]) : '0;
        last_idx = (idx_reg == IDX_W'(NUM_THREADS - 1));

        state_next      = state_reg;
        idx_next        = idx_reg;
        cand_next       = cand_reg;
        rand_next       = rand_reg;
        total_next      = total_reg;
        run_next        = run_reg;
        ticket_next     = ticket_reg;
        pick_next       = pick_reg;
        pick_valid_next = pick_valid_reg;
        done_flag_next  = done_flag_reg;
        finished_next   = finished_reg;
        cur_thread_next = cur_thread_reg;
        cur_valid_next  = cur_valid_reg;
        div_start       = 1'b0;

        out_valid_next  = out_valid_reg && !res.ready;
        out_thread_next = out_thread_reg;
        out_chosen_next = out_chosen_reg;
        out_done_next   = out_done_reg;
        out_total_next  = out_total_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    finished_next   = fin_mark;
                    cand_next       = cand_new;
                    rand_next       = req.random_value;
                    idx_next        = '0;
                    total_next      = '0;
                    pick_next       = '0;
                    pick_valid_next = 1'b0;
                    if (cand_new == '0)
                    begin
                        done_flag_next = 1'b1;
                        cur_valid_next = 1'b0;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        done_flag_next = 1'b0;
                        state_next     = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                total_next = total_reg + tkt_sel;
                idx_next   = idx_reg + 1'b1;
                if (last_idx)
                begin
                    idx_next = '0;
                    if (total_next == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    ticket_next = div_rem;
                    run_next    = '0;
                    idx_next    = '0;
                    state_next  = ST_PICK;
                end
            end
            ST_PICK:
            begin
                run_next = run_reg + tkt_sel;
                idx_next = idx_reg + 1'b1;
                if (cand_reg[idx_reg] && (run_next > ticket_reg))
                begin
                    pick_next       = idx_reg;
                    pick_valid_next = 1'b1;
                    cur_thread_next = idx_reg;
                    cur_valid_next  = 1'b1;
                    state_next      = ST_DONE;
                end
                else if (last_idx)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_thread_next = THREAD_W'(pick_reg);
                    out_chosen_next = pick_valid_reg;
                    out_done_next   = done_flag_reg;
                    out_total_next  = total_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            finished_reg   <= '0;
            cur_thread_reg <= '0;
            cur_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            finished_reg   <= finished_next;
            cur_thread_reg <= cur_thread_next;
            cur_valid_reg  <= cur_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        cand_reg       <= cand_next;
        rand_reg       <= rand_next;
        total_reg      <= total_next;
        run_reg        <= run_next;
        ticket_reg     <= ticket_next;
        pick_reg       <= pick_next;
        pick_valid_reg <= pick_valid_next;
        done_flag_reg  <= done_flag_next;
        out_thread_reg <= out_thread_next;
        out_chosen_reg <= out_chosen_next;
        out_done_reg   <= out_done_next;
        out_total_reg  <= out_total_next;
    end

    assign req.ready         = (state_reg == ST_IDLE);
    assign res.valid         = out_valid_reg;
    assign res.chosen_thread = out_thread_reg;
    assign res.chosen_valid  = out_chosen_reg;
    assign res.all_done      = out_done_reg;
    assign res.ticket_total  = out_total_reg;

endmodule

### hw/rtl/lotp_checker.sv
// Port-level checker for the lottery thread picker, bound to the top level.
// Depends on lotp_pkg for field widths and on lottery_thread_picker.
`timescale 1ns / 1ps

module lotp_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  logic                          res_valid,
    input  logic                          res_ready,
    input  logic [lotp_pkg::THREAD_W-1:0] chosen_thread,
    input  logic                          chosen_valid,
    input  logic                          all_done,
    input  logic [lotp_pkg::TOTAL_W-1:0]  ticket_total
);
    import lotp_pkg::*;

    // A stalled result word holds.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(chosen_thread)
            && $stable(chosen_valid) && $stable(all_done) && $stable(ticket_total))
        else $error("result word changed while stalled");

    // The block works on one request at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while a request is in flight");

    // A pick and the all-done report exclude each other.
    a_pick_or_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(chosen_valid && all_done))
        else $error("thread picked while all threads are done");

    // All done reports no thread and no tickets.
    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && all_done |-> (ticket_total == '0) && (chosen_thread == '0))
        else $error("all-done word carries a thread or tickets");

    // A pick needs a nonzero ticket total.
    a_pick_total: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && chosen_valid |-> (ticket_total != '0))
        else $error("thread picked from a zero ticket total");

endmodule

bind lottery_thread_picker lotp_checker u_lotp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .chosen_thread (res.chosen_thread),
    .chosen_valid  (res.chosen_valid),
    .all_done      (res.all_done),
    .ticket_total  (res.ticket_total)
);

### tb/lotp_pick_checker.sv
// Checker for the lottery thread picker: watches the request, result and register ports.
// Keeps its own copy of the scheduler state, predicts each result word and compares it.
// Depends on lotp_pkg and the lotp_req_if / lotp_res_if interfaces.
`timescale 1ns / 1ps

module lotp_pick_checker
    import lotp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    lotp_req_if                   req,
    lotp_res_if                   res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending,
    output int                    checked,
    output int                    unpicked
);

    typedef struct packed {
        logic [THREAD_W-1:0] thread;
        logic                picked;
        logic                done;
        logic [TOTAL_W-1:0]  total;
    } pick_t;

    logic [CFG_DATA_W-1:0] tickets [4];
    logic [TCOUNT_W-1:0]   tcount;
    logic [3:0]            finished;
    logic [THREAD_W-1:0]   cur;
    logic                  cur_valid;
    pick_t                 picks_due [$];

    // Updates the scheduler state for one request word and returns the result it causes.
    function automatic pick_t draw_lottery(lotp_req_t kind, logic [RAND_W-1:0] rnd);
        int                  n;
        int                  i;
        logic [3:0]          cand;
        logic                cur_live;
        logic [TOTAL_W-1:0]  sum;
        logic [TOTAL_W-1:0]  run;
        logic [RAND_W-1:0]   ticket;
        pick_t               p;

        n = (tcount > 3'd4) ? 4 : int'(tcount);
        p = '0;
        if (kind == REQ_FINISH && cur_valid)
            finished[cur] = 1'b1;
        cur_live = cur_valid && (int'(cur) < n);
        cand = '0;
        for (i = 0; i < n; i++)
            if (!finished[i] && !(cur_live && int'(cur) == i))
                cand[i] = 1'b1;
        // The running thread is the fallback when nobody else is left.
        if (cand == '0 && cur_live && !finished[cur])
            cand[cur] = 1'b1;
        if (cand == '0)
        begin
            p.done = 1'b1;
            cur_valid = 1'b0;
            return p;
        end
        sum = '0;
        for (i = 0; i < n; i++)
            if (cand[i])
                sum += tickets[i];
        p.total = sum;
        if (sum != '0)
        begin
            ticket = rnd % sum;
            run = '0;
            for (i = 0; i < n; i++)
            begin
                if (cand[i] && !p.picked)
                begin
                    run += tickets[i];
                    if (run > ticket)
                    begin
                        p.thread = THREAD_W'(i);
                        p.picked = 1'b1;
                        cur = THREAD_W'(i);
                        cur_valid = 1'b1;
                    end
                end
            end
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pick_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                tickets[i] = CFG_DATA_W'(1);
            tcount = TCOUNT_RESET;
            finished = '0;
            cur = '0;
            cur_valid = 1'b0;
            picks_due.delete();
            errors = 0;
            pending = 0;
            checked = 0;
            unpicked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (lotp_reg_t'(cfg_index))
                    REG_TICKETS_0:    tickets[0] = cfg_data;
                    REG_TICKETS_1:    tickets[1] = cfg_data;
                    REG_TICKETS_2:    tickets[2] = cfg_data;
                    REG_TICKETS_3:    tickets[3] = cfg_data;
                    REG_THREAD_COUNT: tcount = cfg_data[TCOUNT_W-1:0];
                    default:          ;
                endcase
            end
            if (req.valid && req.ready)
                picks_due.push_back(draw_lottery(lotp_req_t'(req.req_type), req.random_value));
            if (res.valid && res.ready)
            begin
                checked++;
                if (!res.chosen_valid)
                    unpicked++;
                if (picks_due.size() == 0)
                begin
                    $error("result word with no draw outstanding");
                    errors++;
                end
                else
                begin
                    want = picks_due.pop_front();
                    if (res.chosen_thread !== want.thread)
                    begin
                        $error("chosen_thread: expected %0d, got %0d", want.thread,
                               res.chosen_thread);
                        errors++;
                    end
                    if (res.chosen_valid !== want.picked)
                    begin
                        $error("chosen_valid: expected %0d, got %0d", want.picked,
                               res.chosen_valid);
                        errors++;
                    end
                    if (res.all_done !== want.done)
                    begin
                        $error("all_done: expected %0d, got %0d", want.done, res.all_done);
                        errors++;
                    end
                    if (res.ticket_total !== want.total)
                    begin
                        $error("ticket_total: expected %0d, got %0d", want.total,
                               res.ticket_total);
                        errors++;
                    end
                end
            end
            pending = picks_due.size();
        end
    end

endmodule

### tb/tb_lottery_thread_picker.sv
// Testbench top for the lottery thread picker: clock, reset, request and register stimulus.
// Prediction and comparison live in lotp_pick_checker; this module gives the verdict.
// Depends on lotp_pkg, the channel interfaces, the block and the checker.
`timescale 1ns / 1ps

module tb_lottery_thread_picker;
    import lotp_pkg::*;

    localparam int STUCK_LIMIT  = 4000;
    localparam int RAND_PHASES  = 16;
    localparam int PHASE_WORDS  = 58;
    localparam int HOLD_AT      = 200;
    localparam int HOLD_CYCLES  = 150;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int errors;
    int pending;
    int checked;
    int unpicked;
    int sent;
    int writes;
    int settings;
    int taken;
    int stuck;
    bit fast_send;

    lotp_req_if req_ch ();
    lotp_res_if res_ch ();

    lottery_thread_picker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lotp_pick_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked),
        .unpicked  (unpicked)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Any accepted word on either channel counts as progress.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= STUCK_LIMIT)
        begin
            $display("tb_lottery_thread_picker: errors");
            $finish;
        end
    end

    task automatic send_word(lotp_req_t kind, logic [RAND_W-1:0] rnd);
        int gap;
        gap = fast_send ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.random_value <= rnd;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
        sent++;
    endtask

    task automatic write_reg(lotp_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        writes++;
    endtask

    // Registers are only touched once every outstanding draw has been answered.
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        settings++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_tickets();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'hFFFF;
            2, 3, 4: return CFG_DATA_W'($urandom_range(1, 7));
            default: return CFG_DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [TCOUNT_W-1:0] pick_count();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return TCOUNT_W'($urandom_range(5, 7));
            2, 3:    return TCOUNT_W'(1);
            4, 5:    return TCOUNT_W'(2);
            6, 7:    return TCOUNT_W'(3);
            default: return TCOUNT_W'(4);
        endcase
    endfunction

    function automatic logic [RAND_W-1:0] pick_random();
        case ($urandom_range(0, 7))
            0:       return RAND_W'($urandom_range(0, 15));
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Result side: random stalls, one long hold-off, and a window with no stalls.
    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken == HOLD_AT)
                stall = HOLD_CYCLES;
            else if (taken >= 400 && taken < 500)
                stall = 0;
            else
                stall = $urandom_range(0, 5);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            taken++;
            @(negedge clk);
        end
    end

    initial
    begin
        bit finishing;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_DRAW;
        req_ch.random_value = '0;
        sent = 0;
        writes = 0;
        settings = 0;
        fast_send = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Largest tickets while no thread runs yet: all four threads are candidates.
        for (int r = 0; r < 4; r++)
            write_reg(lotp_reg_t'(CFG_IDX_W'(r)), 16'hFFFF);
        send_word(REQ_FINISH, 32'hFFFF_FFFF);
        send_word(REQ_DRAW, 32'h0);
        send_word(REQ_DRAW, 32'hFFFF_FFFF);
        send_word(REQ_DRAW, 32'h0001_0000);
        settle();

        // Thread count above the limit saturates; zero and tiny ticket counts.
        write_reg(REG_TICKETS_0, 16'h0000);
        write_reg(REG_TICKETS_1, 16'h0001);
        write_reg(REG_TICKETS_2, 16'hFFFF);
        write_reg(REG_TICKETS_3, 16'h8000);
        write_reg(REG_THREAD_COUNT, 16'd7);
        send_word(REQ_DRAW, 32'h0);
        send_word(REQ_DRAW, 32'h1);
        send_word(REQ_DRAW, 32'hFFFF_FFFF);
        send_word(REQ_DRAW, 32'h7FFF_FFFF);
        settle();

        // One thread with no tickets: candidates exist but nothing can be picked.
        write_reg(REG_THREAD_COUNT, 16'd1);
        send_word(REQ_DRAW, 32'h0000_3039);
        send_word(REQ_DRAW, 32'hDEAD_BEEF);
        settle();

        // No thread in use: all done, which also drops the running thread.
        write_reg(REG_THREAD_COUNT, 16'd0);
        send_word(REQ_DRAW, 32'hA5A5_A5A5);
        send_word(REQ_FINISH, 32'h0);
        settle();

        // Pick thread 3, then shrink the count so the running thread falls outside it.
        for (int r = 0; r < 4; r++)
            write_reg(lotp_reg_t'(CFG_IDX_W'(r)), 16'h0001);
        write_reg(REG_THREAD_COUNT, 16'd4);
        send_word(REQ_DRAW, 32'h3);
        settle();
        write_reg(REG_THREAD_COUNT, 16'd2);
        send_word(REQ_DRAW, 32'hFFFF_FFFF);
        send_word(REQ_DRAW, 32'h0);
        settle();

        // Random settings. Finished threads stay finished until reset, so finish
        // requests stay rare until the last phases, which run every thread out.
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            for (int r = 0; r < 4; r++)
                write_reg(lotp_reg_t'(CFG_IDX_W'(r)), pick_tickets());
            if (ph == RAND_PHASES - 1)
                write_reg(REG_THREAD_COUNT, 16'd4);
            else
                write_reg(REG_THREAD_COUNT, CFG_DATA_W'(pick_count()));
            fast_send = (ph == 5 || ph == 6);
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                if (ph < RAND_PHASES - 3)
                    finishing = ($urandom_range(0, 299) == 0);
                else
                    finishing = ($urandom_range(0, 3) == 0);
                send_word(finishing ? REQ_FINISH : REQ_DRAW, pick_random());
            end
            settle();
        end

        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);

        $display("Sent %0d request words and %0d register writes across %0d settings.",
                 sent, writes, settings);
        $display("Checked %0d result words, %0d of them without a chosen thread.",
                 checked, unpicked);
        if (errors == 0)
            $display("tb_lottery_thread_picker: clean");
        else
            $display("tb_lottery_thread_picker: errors");
        $finish;
    end

endmodule

### files.f
hw/rtl/lotp_pkg.sv
hw/rtl/lotp_req_if.sv
hw/rtl/lotp_rem.sv
hw/rtl/lottery_thread_picker.sv
hw/rtl/lotp_checker.sv
tb/lotp_pick_checker.sv
tb/tb_lottery_thread_picker.sv
